@@ src/tblf_pkg.sv @@
// Shared constants, operation codes and interface types of the label fusion block.
package tblf_pkg;

    localparam int ENTRIES = 3;
    localparam int MERGED  = 2 * ENTRIES;

    localparam int COLOR_W = 24;
    localparam int CONF_W  = 17;
    localparam int PART_W  = CONF_W + 1;
    localparam int MUL_W   = CONF_W + PART_W;
    localparam int PROD_W  = MUL_W - 16;
    localparam int TOT_W   = PROD_W + $clog2(MERGED + 2);
    localparam int LACC_W  = CONF_W + $clog2(ENTRIES + 1) + 1;
    localparam int LIDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MIDX_W  = $clog2(MERGED);
    localparam int NCNT_W  = $clog2(MERGED + 1);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int QUO_W   = 17;
    localparam int QCNT_W  = $clog2(QUO_W + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [CONF_W-1:0] ONE_Q16     = CONF_W'(65536);
    localparam logic [CONF_W-1:0] EPS_RESET   = CONF_W'(66);
    localparam logic [CONF_W-1:0] SHARE_RESET = CONF_W'(52429);

    localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE   = 1'b1;

    localparam logic [4:0] OP_NONE   = 5'd0;
    localparam logic [4:0] OP_INIT   = 5'd1;
    localparam logic [4:0] OP_LACC   = 5'd2;
    localparam logic [4:0] OP_LFLOOR = 5'd3;
    localparam logic [4:0] OP_SH1    = 5'd4;
    localparam logic [4:0] OP_PR1    = 5'd5;
    localparam logic [4:0] OP_ST1    = 5'd6;
    localparam logic [4:0] OP_SH2    = 5'd7;
    localparam logic [4:0] OP_PR2    = 5'd8;
    localparam logic [4:0] OP_ST2    = 5'd9;
    localparam logic [4:0] OP_TMUL   = 5'd10;
    localparam logic [4:0] OP_TADD   = 5'd11;
    localparam logic [4:0] OP_DINIT  = 5'd12;
    localparam logic [4:0] OP_DSTEP  = 5'd13;
    localparam logic [4:0] OP_DDONE  = 5'd14;
    localparam logic [4:0] OP_SINIT  = 5'd15;
    localparam logic [4:0] OP_SSCAN  = 5'd16;
    localparam logic [4:0] OP_EMIT   = 5'd17;

    typedef struct packed {
        logic [4:0]        op;
        logic [MIDX_W-1:0] idx;
        logic              load;
        logic              last;
    } tblf_cmd_t;

    typedef struct packed {
        logic              start_req;
        logic              hit2;
        logic              out_free;
        logic [NCNT_W-1:0] n;
    } tblf_status_t;

endpackage

@@ src/tblf_ctrl.sv @@
// Sequencing state machine of the label fusion block.
module tblf_ctrl
    import tblf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  tblf_status_t status,
    output tblf_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_INIT   = 5'd1;
    localparam logic [4:0] S_LACC   = 5'd2;
    localparam logic [4:0] S_LFLOOR = 5'd3;
    localparam logic [4:0] S_SH1    = 5'd4;
    localparam logic [4:0] S_PR1    = 5'd5;
    localparam logic [4:0] S_ST1    = 5'd6;
    localparam logic [4:0] S_SH2    = 5'd7;
    localparam logic [4:0] S_PR2    = 5'd8;
    localparam logic [4:0] S_ST2    = 5'd9;
    localparam logic [4:0] S_TMUL   = 5'd10;
    localparam logic [4:0] S_TADD   = 5'd11;
    localparam logic [4:0] S_DINIT  = 5'd12;
    localparam logic [4:0] S_DSTEP  = 5'd13;
    localparam logic [4:0] S_DDONE  = 5'd14;
    localparam logic [4:0] S_SINIT  = 5'd15;
    localparam logic [4:0] S_SSCAN  = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    localparam logic [MIDX_W-1:0] LIST_END = MIDX_W'(ENTRIES - 1);
    localparam logic [LIDX_W-1:0] K_END    = LIDX_W'(ENTRIES - 1);
    localparam logic [QCNT_W-1:0] Q_END    = QCNT_W'(QUO_W - 1);

    logic [4:0]        state_reg, state_next;
    logic [MIDX_W-1:0] idx_reg, idx_next;
    logic [LIDX_W-1:0] k_reg, k_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic              idx_at_n;

    assign idx_at_n = (NCNT_W'(idx_reg) + NCNT_W'(1)) == status.n;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        qcnt_next  = qcnt_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = idx_reg;
        cmd.load   = in_valid && (state_reg == S_IDLE);
        cmd.last   = (k_reg == K_END);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.start_req)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                idx_next   = '0;
                state_next = S_LACC;
            end
            S_LACC:
            begin
                cmd.op   = OP_LACC;
                idx_next = idx_reg + MIDX_W'(1);
                if (idx_reg == LIST_END)
                begin
                    idx_next   = '0;
                    state_next = S_LFLOOR;
                end
            end
            S_LFLOOR:
            begin
                cmd.op     = OP_LFLOOR;
                state_next = S_SH1;
            end
            S_SH1:
            begin
                cmd.op     = OP_SH1;
                state_next = S_PR1;
            end
            S_PR1:
            begin
                cmd.op     = OP_PR1;
                state_next = S_ST1;
            end
            S_ST1:
            begin
                cmd.op   = OP_ST1;
                idx_next = idx_reg + MIDX_W'(1);
                state_next = S_SH1;
                if (idx_reg == LIST_END)
                begin
                    idx_next   = '0;
                    state_next = S_SH2;
                end
            end
            S_SH2:
            begin
                if (status.hit2)
                begin
                    idx_next = idx_reg + MIDX_W'(1);
                    if (idx_reg == LIST_END)
                    begin
                        state_next = S_TMUL;
                    end
                end
                else
                begin
                    cmd.op     = OP_SH2;
                    state_next = S_PR2;
                end
            end
            S_PR2:
            begin
                cmd.op     = OP_PR2;
                state_next = S_ST2;
            end
            S_ST2:
            begin
                cmd.op     = OP_ST2;
                idx_next   = idx_reg + MIDX_W'(1);
                state_next = (idx_reg == LIST_END) ? S_TMUL : S_SH2;
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                cmd.op     = OP_TADD;
                idx_next   = '0;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DINIT;
                qcnt_next  = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op    = OP_DSTEP;
                qcnt_next = qcnt_reg + QCNT_W'(1);
                if (qcnt_reg == Q_END)
                begin
                    state_next = S_DDONE;
                end
            end
            S_DDONE:
            begin
                cmd.op   = OP_DDONE;
                idx_next = idx_reg + MIDX_W'(1);
                state_next = S_DINIT;
                if (idx_at_n)
                begin
                    k_next     = '0;
                    state_next = S_SINIT;
                end
            end
            S_SINIT:
            begin
                cmd.op     = OP_SINIT;
                idx_next   = '0;
                state_next = S_SSCAN;
            end
            S_SSCAN:
            begin
                cmd.op   = OP_SSCAN;
                idx_next = idx_reg + MIDX_W'(1);
                if (idx_at_n)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    k_next     = k_reg + LIDX_W'(1);
                    state_next = (k_reg == K_END) ? S_IDLE : S_SINIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
            qcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            qcnt_reg  <= qcnt_next;
        end
    end

endmodule

@@ src/tblf_dp.sv @@
// Datapath of the label fusion block: list storage, shared multiplier, divider and selection.
module tblf_dp
    import tblf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CONF_W-1:0]    cfg_data,
    input  logic                 second_list,
    input  logic [COLOR_W-1:0]   label_color,
    input  logic [CONF_W-1:0]    confidence,
    input  logic                 last_entry,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [COLOR_W-1:0]   fused_color,
    output logic [CONF_W-1:0]    fused_confidence,
    output logic                 last_result,
    input  tblf_cmd_t            cmd,
    output tblf_status_t         status
);

    logic [CONF_W-1:0]  eps_reg, share_reg;
    logic [CNT_W-1:0]   cnt1_reg, cnt2_reg;

    logic [COLOR_W-1:0] col1_reg [ENTRIES];
    logic [CONF_W-1:0]  conf1_reg [ENTRIES];
    logic [COLOR_W-1:0] col2_reg [ENTRIES];
    logic [CONF_W-1:0]  conf2_reg [ENTRIES];

    logic signed [LACC_W-1:0] lacc1_reg, lacc2_reg;
    logic [CONF_W-1:0]  left1_reg, left2_reg;
    logic [MUL_W-1:0]   mul_reg;

    logic [COLOR_W-1:0] mcol_reg [MERGED];
    logic [PROD_W-1:0]  mprod_reg [MERGED];
    logic [CONF_W-1:0]  mconf_reg [MERGED];
    logic [MERGED-1:0]  used_reg;
    logic [NCNT_W-1:0]  n_reg;
    logic [TOT_W-1:0]   sum_reg, total_reg, rem_reg;
    logic [QUO_W-1:0]   low_reg, q_reg;
    logic [MIDX_W-1:0]  best_reg;
    logic               best_ok_reg;
    logic [CONF_W-1:0]  best_conf_reg;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [CONF_W-1:0]  out_conf_reg;
    logic               out_last_reg;

    logic [LIDX_W-1:0]  li;
    logic [MIDX_W-1:0]  n_idx;
    logic               hit1, hit2;
    logic [CONF_W-1:0]  match_conf;
    logic [PART_W-1:0]  part, c2;
    logic [PROD_W-1:0]  prod;
    logic [CONF_W-1:0]  mul_a;
    logic [PART_W-1:0]  mul_b;
    logic [CONF_W-1:0]  left1_sat, left2_sat;
    logic signed [LACC_W-1:0] eps_s;
    logic [TOT_W:0]     trial;
    logic               trial_ge;
    logic [QUO_W-1:0]   quo;
    logic               out_free;

    assign li    = cmd.idx[LIDX_W-1:0];
    assign n_idx = n_reg[MIDX_W-1:0];
    assign part  = mul_reg[PART_W+15:16];
    assign prod  = mul_reg[MUL_W-1:16];
    assign eps_s = $signed({{(LACC_W-CONF_W){1'b0}}, eps_reg});
    assign out_free = !out_valid_reg || !out_stall;

    // First list-two match for list-one entry li; hit2: list-two entry li is in list one.
    always_comb
    begin
        hit1       = 1'b0;
        match_conf = '0;
        hit2       = 1'b0;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (col1_reg[li] == col2_reg[j])
            begin
                hit1       = 1'b1;
                match_conf = conf2_reg[j];
            end
            if (col2_reg[li] == col1_reg[j])
            begin
                hit2 = 1'b1;
            end
        end
    end

    assign c2 = hit1 ? {1'b0, match_conf} : part;
    assign left1_sat = (part >= {1'b0, left1_reg}) ? '0 : (left1_reg - part[CONF_W-1:0]);
    assign left2_sat = (part >= {1'b0, left2_reg}) ? '0 : (left2_reg - part[CONF_W-1:0]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SH1:
            begin
                mul_a = share_reg;
                mul_b = {1'b0, left2_reg};
            end
            OP_PR1:
            begin
                mul_a = conf1_reg[li];
                mul_b = c2;
            end
            OP_SH2:
            begin
                mul_a = share_reg;
                mul_b = {1'b0, left1_reg};
            end
            OP_PR2:
            begin
                mul_a = conf2_reg[li];
                mul_b = part;
            end
            OP_TMUL:
            begin
                mul_a = left1_reg;
                mul_b = {1'b0, left2_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign trial    = {rem_reg, low_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, total_reg};
    assign quo      = (total_reg == '0) ? '0 : q_reg;

    assign status.start_req = second_list && last_entry;
    assign status.hit2      = hit2;
    assign status.out_free  = out_free;
    assign status.n         = n_reg;

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg       <= EPS_RESET;
            share_reg     <= SHARE_RESET;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            n_reg         <= '0;
            used_reg      <= '0;
            best_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_EPSILON: eps_reg   <= cfg_data;
                    REG_SHARE:   share_reg <= cfg_data;
                    default:     eps_reg   <= eps_reg;
                endcase
            end
            if (cmd.load)
            begin
                if (!second_list && (cnt1_reg < CNT_W'(ENTRIES)))
                begin
                    cnt1_reg <= cnt1_reg + CNT_W'(1);
                end
                if (second_list && (cnt2_reg < CNT_W'(ENTRIES)))
                begin
                    cnt2_reg <= cnt2_reg + CNT_W'(1);
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op) inside
                OP_INIT:
                begin
                    n_reg    <= '0;
                    used_reg <= '0;
                end
                OP_ST1, OP_ST2:
                begin
                    n_reg <= n_reg + NCNT_W'(1);
                end
                OP_SINIT:
                begin
                    best_ok_reg <= 1'b0;
                end
                OP_SSCAN:
                begin
                    if (!used_reg[cmd.idx]
                        && (!best_ok_reg || (mconf_reg[cmd.idx] > best_conf_reg)))
                    begin
                        best_ok_reg <= 1'b1;
                    end
                end
                OP_EMIT:
                begin
                    used_reg[best_reg] <= 1'b1;
                    out_valid_reg      <= 1'b1;
                    if (cmd.last)
                    begin
                        cnt1_reg <= '0;
                        cnt2_reg <= '0;
                    end
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

    // Payload storage and arithmetic.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (!second_list && (cnt1_reg < CNT_W'(ENTRIES)))
            begin
                col1_reg[cnt1_reg[LIDX_W-1:0]]  <= label_color;
                conf1_reg[cnt1_reg[LIDX_W-1:0]] <= confidence;
            end
            if (second_list && (cnt2_reg < CNT_W'(ENTRIES)))
            begin
                col2_reg[cnt2_reg[LIDX_W-1:0]]  <= label_color;
                conf2_reg[cnt2_reg[LIDX_W-1:0]] <= confidence;
            end
        end
        case (cmd.op) inside
            OP_INIT:
            begin
                lacc1_reg <= LACC_W'(ONE_Q16);
                lacc2_reg <= LACC_W'(ONE_Q16);
                sum_reg   <= '0;
            end
            OP_LACC:
            begin
                lacc1_reg <= lacc1_reg - $signed({{(LACC_W-CONF_W){1'b0}}, conf1_reg[li]});
                lacc2_reg <= lacc2_reg - $signed({{(LACC_W-CONF_W){1'b0}}, conf2_reg[li]});
            end
            OP_LFLOOR:
            begin
                left1_reg <= (lacc1_reg <= eps_s) ? eps_reg : lacc1_reg[CONF_W-1:0];
                left2_reg <= (lacc2_reg <= eps_s) ? eps_reg : lacc2_reg[CONF_W-1:0];
            end
            OP_SH1, OP_SH2, OP_TMUL:
            begin
                mul_reg <= mul_a * mul_b;
            end
            OP_PR1:
            begin
                mul_reg <= mul_a * mul_b;
                if (!hit1)
                begin
                    left2_reg <= left2_sat;
                end
            end
            OP_PR2:
            begin
                mul_reg   <= mul_a * mul_b;
                left1_reg <= left1_sat;
            end
            OP_ST1:
            begin
                mcol_reg[n_idx]  <= col1_reg[li];
                mprod_reg[n_idx] <= prod;
                sum_reg          <= sum_reg + TOT_W'(prod);
            end
            OP_ST2:
            begin
                mcol_reg[n_idx]  <= col2_reg[li];
                mprod_reg[n_idx] <= prod;
                sum_reg          <= sum_reg + TOT_W'(prod);
            end
            OP_TADD:
            begin
                total_reg <= sum_reg + TOT_W'(prod);
            end
            OP_DINIT:
            begin
                rem_reg <= TOT_W'(mprod_reg[cmd.idx] >> 1);
                low_reg <= {mprod_reg[cmd.idx][0], {(QUO_W-1){1'b0}}};
                q_reg   <= '0;
            end
            OP_DSTEP:
            begin
                rem_reg <= trial_ge ? TOT_W'(trial - {1'b0, total_reg}) : trial[TOT_W-1:0];
                q_reg   <= {q_reg[QUO_W-2:0], trial_ge};
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            end
            OP_DDONE:
            begin
                mconf_reg[cmd.idx] <= (quo < eps_reg) ? eps_reg : quo;
            end
            OP_SSCAN:
            begin
                if (!used_reg[cmd.idx]
                    && (!best_ok_reg || (mconf_reg[cmd.idx] > best_conf_reg)))
                begin
                    best_reg      <= cmd.idx;
                    best_conf_reg <= mconf_reg[cmd.idx];
                end
            end
            OP_EMIT:
            begin
                out_color_reg <= mcol_reg[best_reg];
                out_conf_reg  <= best_conf_reg;
                out_last_reg  <= cmd.last;
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign fused_color      = out_color_reg;
    assign fused_confidence = out_conf_reg;
    assign last_result      = out_last_reg;

endmodule

@@ src/topk_bayesian_label_fusion.sv @@
// Top level of the top-k Bayesian label fusion block.
//
// Usage: the input channel carries one list entry per transfer. An entry with
// second_list low goes to the first list, with second_list high to the second
// list; each list keeps up to ENTRIES entries and ignores extra ones. Entries
// load at one per cycle while in_stall is low. A second-list entry with
// last_entry high is stored and then starts a fusion, during which in_stall
// stays high. A fusion first works out the leftover masses and the products
// on the shared multiplier, then runs each merged entry through the
// bit-serial divider, and then runs the top-k scan, which visits every merged
// entry once per result. The output channel then delivers ENTRIES results,
// best first, with last_result high on the final one. A result sits in an
// output register; the next one is loaded only after it is taken, so a
// stalling receiver simply holds the fusion. Once the last result is loaded,
// new entries are taken even while that result still waits. Configuration
// writes go through the plain write port; the user must keep them to times
// when the block is idle, as the block itself does not enforce this. Reset
// restores epsilon and share to their defaults, empties both lists and drops
// any pending result.
module topk_bayesian_label_fusion
    import tblf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CONF_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 second_list,
    input  logic [COLOR_W-1:0]   label_color,
    input  logic [CONF_W-1:0]    confidence,
    input  logic                 last_entry,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COLOR_W-1:0]   fused_color,
    output logic [CONF_W-1:0]    fused_confidence,
    output logic                 last_result
);

    tblf_cmd_t    cmd;
    tblf_status_t status;

    // The controller walks the fusion steps; the datapath holds all data.
    tblf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tblf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .second_list      (second_list),
        .label_color      (label_color),
        .confidence       (confidence),
        .last_entry       (last_entry),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .fused_color      (fused_color),
        .fused_confidence (fused_confidence),
        .last_result      (last_result),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

@@ src/tblf_chk.sv @@
// Port-level checker of the label fusion block and its bind.
module tblf_chk
    import tblf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               second_list,
    input logic               last_entry,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COLOR_W-1:0] fused_color,
    input logic               last_result
);

    // A transfer that starts a fusion blocks further input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && second_list && last_entry) |=> in_stall)
    else $error("input not blocked after fusion start");

    // While a non-final result is shown, the fusion is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> in_stall)
    else $error("input open before last result");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(fused_color)))
    else $error("stalled result changed");

endmodule

bind topk_bayesian_label_fusion tblf_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .second_list (second_list),
    .last_entry  (last_entry),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fused_color (fused_color),
    .last_result (last_result)
);

@@ test/tb_topk_bayesian_label_fusion.sv @@
// Self-checking testbench of the top-k Bayesian label fusion block.
module tb_topk_bayesian_label_fusion;
    import tblf_pkg::*;

    // One fused label as it leaves the block.
    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [CONF_W-1:0]  conf;
        logic               last;
    } fused_label_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CONF_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 second_list;
    logic [COLOR_W-1:0]   label_color;
    logic [CONF_W-1:0]    confidence;
    logic                 last_entry;
    logic                 out_valid;
    logic                 out_stall;
    logic [COLOR_W-1:0]   fused_color;
    logic [CONF_W-1:0]    fused_confidence;
    logic                 last_result;

    topk_bayesian_label_fusion dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .second_list      (second_list),
        .label_color      (label_color),
        .confidence       (confidence),
        .last_entry       (last_entry),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .fused_color      (fused_color),
        .fused_confidence (fused_confidence),
        .last_result      (last_result)
    );

    // Mirror of the block's state, kept up to date at every accepted transfer.
    logic [CONF_W-1:0]  eps_q;
    logic [CONF_W-1:0]  share_q;
    logic [COLOR_W-1:0] list_color [2][ENTRIES];
    logic [CONF_W-1:0]  list_conf  [2][ENTRIES];
    bit                 slot_seen  [2][ENTRIES];
    int                 fill       [2];

    fused_label_t fused_expected[$];

    int  errors;
    int  items_sent;
    int  fusions_seen;
    int  labels_checked;
    int  idle_cycles;
    bit  quiet;     // when set, neither side inserts gaps or stalls

    // Clock with a 10 unit period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Leftover mass of one list: 1.0 minus its confidences, floored at epsilon.
    function automatic logic [63:0] leftover_mass(int lst);
        longint left;
        left = 65536;
        for (int i = 0; i < ENTRIES; i++)
        begin
            left -= longint'(list_conf[lst][i]);
        end
        if (left <= longint'(eps_q))
        begin
            left = longint'(eps_q);
        end
        return left;
    endfunction

    // Hands the share of a leftover to an unseen color; the leftover
    // saturates at zero when the share is more than it holds.
    function automatic logic [63:0] grant_share(inout logic [63:0] left);
        logic [63:0] part;
        part = (64'(share_q) * left) >> 16;
        left = (part >= left) ? 64'd0 : left - part;
        return part;
    endfunction

    // Computes the labels that one fusion produces and queues them.
    function automatic void predict_fusion();
        logic [63:0]        left1;
        logic [63:0]        left2;
        logic [63:0]        c1;
        logic [63:0]        c2;
        logic [63:0]        total;
        logic [63:0]        v;
        logic [63:0]        prod [MERGED];
        logic [COLOR_W-1:0] mcol [MERGED];
        logic [CONF_W-1:0]  mval [MERGED];
        bit                 taken[MERGED];
        bit                 hit;
        int                 n;
        int                 best;
        fused_label_t       lbl;
        left1 = leftover_mass(0);
        left2 = leftover_mass(1);
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit = 1'b0;
            c2 = '0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (!hit && list_color[0][i] == list_color[1][j])
                begin
                    c2 = 64'(list_conf[1][j]);
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                c2 = grant_share(left2);
            end
            mcol[n] = list_color[0][i];
            prod[n] = (64'(list_conf[0][i]) * c2) >> 16;
            n++;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit = 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (list_color[1][i] == list_color[0][j])
                begin
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                c1 = grant_share(left1);
                mcol[n] = list_color[1][i];
                prod[n] = (c1 * 64'(list_conf[1][i])) >> 16;
                n++;
            end
        end
        total = (left1 * left2) >> 16;
        for (int i = 0; i < n; i++)
        begin
            total += prod[i];
        end
        for (int i = 0; i < n; i++)
        begin
            v = (total == 0) ? 64'd0 : (prod[i] << 16) / total;
            if (v < 64'(eps_q))
            begin
                v = 64'(eps_q);
            end
            mval[i] = v[CONF_W-1:0];
            taken[i] = 1'b0;
        end
        // Top-k pick: a strictly larger value is needed to replace the
        // current best, so ties stay with the earlier merged entry.
        for (int k = 0; k < ENTRIES; k++)
        begin
            best = -1;
            for (int i = 0; i < n; i++)
            begin
                if (!taken[i] && (best < 0 || mval[i] > mval[best]))
                begin
                    best = i;
                end
            end
            if (best < 0)
            begin
                best = 0;
            end
            taken[best] = 1'b1;
            lbl.color = mcol[best];
            lbl.conf = mval[best];
            lbl.last = (k == ENTRIES - 1);
            fused_expected.insert(fused_expected.size(), lbl);
        end
        fill[0] = 0;
        fill[1] = 0;
    endfunction

    // True once every slot of both lists has been written at least once.
    function automatic bit lists_primed();
        for (int l = 0; l < 2; l++)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!slot_seen[l][i])
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Sends one list entry and updates the mirror when the transfer happens.
    // The task leaves in_valid high so that a back-to-back entry needs no gap.
    task automatic send_entry(bit lst, logic [COLOR_W-1:0] color,
                              logic [CONF_W-1:0] conf, bit last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        // A fusion must never read a slot that was never written.
        if (lst && last && !lists_primed() && fill[0] + fill[1] < 2 * ENTRIES)
        begin
            last = 1'b0;
        end
        second_list = lst;
        label_color = color;
        confidence  = conf;
        last_entry  = last;
        in_valid    = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (fill[lst] < ENTRIES)
        begin
            list_color[lst][fill[lst]] = color;
            list_conf[lst][fill[lst]]  = conf;
            slot_seen[lst][fill[lst]]  = 1'b1;
            fill[lst]++;
        end
        items_sent++;
        if (lst && last)
        begin
            fusions_seen++;
            predict_fusion();
        end
    endtask

    // Drops valid and waits until every expected label has been taken, then
    // waits further so that any entry load has settled.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        wait (fused_expected.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CONF_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        if (idx == REG_EPSILON)
        begin
            eps_q = val;
        end
        else
        begin
            share_q = val;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Loads two full lists and starts a fusion with the last second entry.
    task automatic send_lists(logic [COLOR_W-1:0] a0, logic [CONF_W-1:0] p0,
                              logic [COLOR_W-1:0] a1, logic [CONF_W-1:0] p1,
                              logic [COLOR_W-1:0] a2, logic [CONF_W-1:0] p2,
                              logic [COLOR_W-1:0] b0, logic [CONF_W-1:0] q0,
                              logic [COLOR_W-1:0] b1, logic [CONF_W-1:0] q1,
                              logic [COLOR_W-1:0] b2, logic [CONF_W-1:0] q2);
        send_entry(1'b0, a0, p0, 1'b0);
        send_entry(1'b0, a1, p1, 1'b0);
        send_entry(1'b0, a2, p2, 1'b0);
        send_entry(1'b1, b0, q0, 1'b0);
        send_entry(1'b1, b1, q1, 1'b0);
        send_entry(1'b1, b2, q2, 1'b1);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        // A small pool makes shared colors between the lists common.
        if ($urandom_range(0, 3) != 0)
        begin
            return COLOR_W'($urandom_range(1, 6));
        end
        return COLOR_W'($urandom());
    endfunction

    function automatic logic [CONF_W-1:0] pick_conf();
        case ($urandom_range(0, 9))
            0:       return ONE_Q16;
            1:       return CONF_W'($urandom_range(0, 65536));
            2:       return CONF_W'($urandom_range(0, 255));
            default: return CONF_W'($urandom_range(0, 21845));
        endcase
    endfunction

    // Reset values of both registers on a plain fusion with distinct colors.
    task automatic test_reset_defaults();
        send_lists(24'h000001, 17'd30000, 24'h000002, 17'd20000, 24'h000003, 17'd10000,
                   24'h000004, 17'd25000, 24'h000005, 17'd15000, 24'h000006, 17'd5000);
    endtask

    // Field extremes, shared colors, overflow and the other corner cases.
    task automatic test_corner_cases();
        // All-zero and all-ones colors, full and empty confidences, with
        // two shared colors; the sums exceed 1.0 so the leftovers are floored.
        send_lists(24'h000000, ONE_Q16, 24'hFFFFFF, 17'd0, 24'h123456, 17'd40000,
                   24'hFFFFFF, ONE_Q16, 24'h000000, 17'd1, 24'hABCDEF, 17'd40000);
        // Overflow on both lists and last_entry ignored on the first list.
        send_entry(1'b0, 24'h00AA00, 17'd20000, 1'b1);
        send_entry(1'b0, 24'h00BB00, 17'd20000, 1'b0);
        send_entry(1'b0, 24'h00CC00, 17'd20000, 1'b0);
        send_entry(1'b0, 24'h00DD00, 17'd60000, 1'b1);
        send_entry(1'b1, 24'h00CC00, 17'd30000, 1'b0);
        send_entry(1'b1, 24'h00AA00, 17'd30000, 1'b0);
        send_entry(1'b1, 24'h00BB00, 17'd5000, 1'b0);
        send_entry(1'b1, 24'h0000EE, 17'd9999, 1'b1);
        // Equal values in every slot to exercise the tie rule.
        send_lists(24'h111111, 17'd10000, 24'h222222, 17'd10000, 24'h333333, 17'd10000,
                   24'h111111, 17'd10000, 24'h222222, 17'd10000, 24'h333333, 17'd10000);
        // Zero epsilon with lists that sum exactly to 1.0 and share nothing:
        // the total is zero.
        write_register(REG_EPSILON, 17'd0);
        send_lists(24'h010101, 17'd65536, 24'h020202, 17'd0, 24'h030303, 17'd0,
                   24'h040404, 17'd0, 24'h050505, 17'd65536, 24'h060606, 17'd0);
        // A share of 1.0 drives the leftovers to zero.
        write_register(REG_SHARE, ONE_Q16);
        send_lists(24'h0A0A0A, 17'd100, 24'h0B0B0B, 17'd200, 24'h0C0C0C, 17'd300,
                   24'h0D0D0D, 17'd400, 24'h0E0E0E, 17'd500, 24'h0F0F0F, 17'd600);
    endtask

    // Several register settings, the extremes among them.
    task automatic test_register_sweep();
        logic [CONF_W-1:0] eps_set   [5] = '{17'd0, 17'd66, 17'd4096, 17'd65535, ONE_Q16};
        logic [CONF_W-1:0] share_set [5] = '{ONE_Q16, 17'd0, 17'd52429, 17'd32768, 17'd1};
        for (int s = 0; s < 5; s++)
        begin
            write_register(REG_EPSILON, eps_set[s]);
            write_register(REG_SHARE, share_set[s]);
            repeat (2)
            begin
                send_lists(pick_color(), pick_conf(), pick_color(), pick_conf(),
                           pick_color(), pick_conf(), pick_color(), pick_conf(),
                           pick_color(), pick_conf(), pick_color(), pick_conf());
            end
        end
        write_register(REG_EPSILON, EPS_RESET);
        write_register(REG_SHARE, SHARE_RESET);
    endtask

    // Mostly well-formed list pairs with random content, some noise entries
    // and cut-short or overfilled lists in between.
    task automatic test_random_traffic();
        int start;
        int len1;
        int len2;
        start = items_sent;
        while (items_sent - start < 150)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                len1 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : ENTRIES;
                len2 = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : ENTRIES;
                for (int i = 0; i < len1; i++)
                begin
                    send_entry(1'b0, pick_color(), pick_conf(), 1'($urandom_range(0, 1)));
                end
                for (int i = 0; i < len2; i++)
                begin
                    send_entry(1'b1, pick_color(), pick_conf(), i == len2 - 1);
                end
            end
            else
            begin
                send_entry(1'($urandom_range(0, 1)), COLOR_W'($urandom()),
                           CONF_W'($urandom_range(0, 131071)), ($urandom_range(0, 3) == 0));
            end
        end
        quiet = 1'b0;
    endtask

    // The sender holds off until every expected label has arrived, then
    // sends a fusion back to back with no gaps.
    task automatic test_drain_pause();
        wait_drained();
        quiet = 1'b1;
        send_lists(24'hC0FFEE, 17'd12345, 24'h00BEEF, 17'd23456, 24'hFACADE, 17'd345,
                   24'h00BEEF, 17'd999, 24'hDEC0DE, 17'd30000, 24'hC0FFEE, 17'd111);
        quiet = 1'b0;
    endtask

    // Receiver: stalls a random number of cycles before each label, then
    // checks it against the oldest expectation.
    initial
    begin
        int gap;
        fused_label_t want;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            out_stall = (gap > 0);
            repeat (gap) @(negedge clk);
            out_stall = 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            labels_checked++;
            if (fused_expected.size() == 0)
            begin
                $display("%0t: unexpected label color %h conf %0d last %0b", $time,
                         fused_color, fused_confidence, last_result);
                errors++;
            end
            else
            begin
                want = fused_expected.pop_front();
                if (fused_color !== want.color)
                begin
                    $display("%0t: fused_color expected %h actual %h", $time,
                             want.color, fused_color);
                    errors++;
                end
                if (fused_confidence !== want.conf)
                begin
                    $display("%0t: fused_confidence expected %0d actual %0d", $time,
                             want.conf, fused_confidence);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             want.last, last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog: even allowing for a fusion and receiver stalls, a long stretch
    // without any transfer means the block hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 5000)
        begin
            $display("%0t: watchdog expired with %0d labels outstanding", $time,
                     fused_expected.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        items_sent = 0;
        fusions_seen = 0;
        labels_checked = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        eps_q = EPS_RESET;
        share_q = SHARE_RESET;
        fill = '{0, 0};
        for (int l = 0; l < 2; l++)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                list_color[l][i] = '0;
                list_conf[l][i] = '0;
                slot_seen[l][i] = 1'b0;
            end
        end
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_EPSILON;
        cfg_data = '0;
        in_valid = 1'b0;
        second_list = 1'b0;
        label_color = '0;
        confidence = '0;
        last_entry = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_corner_cases();
        test_register_sweep();
        test_random_traffic();
        test_drain_pause();

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Sent %0d list entries covering %0d fusions; checked %0d fused labels.",
                 items_sent, fusions_seen, labels_checked);
        if (errors == 0 && fused_expected.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("%0d errors, %0d labels never arrived", errors, fused_expected.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/tblf_pkg.sv
src/tblf_ctrl.sv
src/tblf_dp.sv
src/topk_bayesian_label_fusion.sv
src/tblf_chk.sv
test/tb_topk_bayesian_label_fusion.sv
